>>> src/gasc_pkg.sv
// Package: shared types and constants of the glyph atlas slot cache.
package gasc_pkg;

	// Register word indexes on the configuration port
	localparam logic REG_CELL_SIZE  = 1'b0;
	localparam logic REG_GRID_WIDTH = 1'b1;

	// Register reset values
	localparam logic [7:0] CELL_SIZE_RST  = 8'd32;
	localparam logic [6:0] GRID_WIDTH_RST = 7'd33;

	// Input action codes
	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_FLUSH  = 1'b1;

	// Status codes
	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_FULL = 1'b1;

	// Sequencer states
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SCAN  = 7'b0000010,
		ST_ALLOC = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_MUL   = 7'b0010000,
		ST_MARK  = 7'b0100000,
		ST_CLR   = 7'b1000000
	} state_t;

endpackage

>>> src/gasc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gasc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/gasc_div.sv
// Iterative restoring divider: slot number by grid width, one quotient bit a cycle.
module gasc_div #(
	parameter int W = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [6:0]   divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [6:0]   rem
);

	localparam int CNTW = $clog2(W + 1);

	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [W-1:0]    quot_q;
	logic [6:0]      rem_q;
	logic [7:0]      trial;
	logic            qbit;
	logic [7:0]      diff;

	// one restoring step
	always_comb begin
		trial = {rem_q, quot_q[W-1]};
		qbit  = (trial >= {1'b0, divisor});
		diff  = trial - {1'b0, divisor};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNTW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (run_q) begin
			quot_q <= W'({quot_q, qbit});
			rem_q  <= qbit ? diff[6:0] : trial[6:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

>>> src/glyph_atlas_slot_cache.sv
// Top level: glyph atlas slot cache, table scan, slot allocation and rectangle math.
//
//  channel  | signals                                        | handshake
//  ---------+------------------------------------------------+-------------------------
//  input    | action code_point glyph_width glyph_height     | start & !busy
//  result   | hit slot rect_x rect_y rect_w rect_h flush     | done, one cycle
//           | status                                         |
//  config   | psel penable pwrite paddr pwdata prdata pready | psel & penable & pwrite
//
// A lookup reads the keys of the filled slots, one key read a cycle, until it hits or the
// filled slots run out; a miss then takes a free slot, and the divider makes one bit a
// cycle.
// A flush action answers in the cycle after it is accepted, then the mark memory is swept.
// After reset busy stays high while the mark memory is cleared.
// A batch-full flush also sweeps the marks. The receiver cannot stall results.
module glyph_atlas_slot_cache #(
	parameter int SLOTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// input word
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [20:0] code_point,
	input  logic [7:0]  glyph_width,
	input  logic [7:0]  glyph_height,
	// result word
	output logic        done,
	output logic        hit,
	output logic [9:0]  slot,
	output logic [13:0] rect_x,
	output logic [13:0] rect_y,
	output logic [7:0]  rect_w,
	output logic [7:0]  rect_h,
	output logic        flush,
	output logic        status,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int KVW = 37;

	gasc_pkg::state_t state_q;

	// configuration registers
	logic [7:0] cell_size_q;
	logic [6:0] grid_width_q;

	// per-item registers
	logic [20:0]   cp_q;
	logic [7:0]    gw_in_q;
	logic [7:0]    gh_in_q;
	logic [AW-1:0] found_q;
	logic          hit_q;
	logic [7:0]    w_q;
	logic [7:0]    h_q;
	logic [CW-1:0] scan_q;
	logic          pend_q;
	logic [AW-1:0] pend_addr_q;
	logic          div_go_q;
	logic          mark_rd_q;
	logic          mark_q;
	logic [13:0]   x_q;
	logic [13:0]   y_q;

	// global state
	logic [CW-1:0] free_q;
	logic [CW-1:0] used_q;
	logic [AW-1:0] clr_q;

	// result registers
	logic        done_q;
	logic        hit_o_q;
	logic [9:0]  slot_o_q;
	logic [13:0] x_o_q;
	logic [13:0] y_o_q;
	logic [7:0]  w_o_q;
	logic [7:0]  h_o_q;
	logic        flush_o_q;
	logic        status_o_q;

	// memory ports
	logic           kv_we;
	logic [AW-1:0]  kv_waddr;
	logic [KVW-1:0] kv_wdata;
	logic           kv_re;
	logic [KVW-1:0] kv_rdata;
	logic           mk_we;
	logic [AW-1:0]  mk_waddr;
	logic           mk_wdata;
	logic           mk_re;
	logic           mk_rdata;

	// divider
	logic          div_start;
	logic          div_done;
	logic [AW-1:0] div_quot;
	logic [6:0]    div_rem;
	logic [6:0]    gw_eff;

	logic          key_match;
	logic          accept;
	logic [CW-1:0] used_next;
	logic [14:0]   prod_x;
	logic [AW+7:0] prod_y;
	logic          cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	always_comb begin
		case (paddr[2])
			gasc_pkg::REG_CELL_SIZE:  prdata = {24'd0, cell_size_q};
			gasc_pkg::REG_GRID_WIDTH: prdata = {25'd0, grid_width_q};
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q  <= gasc_pkg::CELL_SIZE_RST;
			grid_width_q <= gasc_pkg::GRID_WIDTH_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == gasc_pkg::REG_CELL_SIZE) begin
				cell_size_q <= pwdata[7:0];
			end else begin
				grid_width_q <= pwdata[6:0];
			end
		end
	end

	// memories: key+size table and used marks
	gasc_ram #(.WIDTH(KVW), .DEPTH(SLOTS)) u_kv_ram (
		.clk   (clk),
		.we    (kv_we),
		.waddr (kv_waddr),
		.wdata (kv_wdata),
		.re    (kv_re),
		.raddr (scan_q[AW-1:0]),
		.rdata (kv_rdata)
	);

	gasc_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_mark_ram (
		.clk   (clk),
		.we    (mk_we),
		.waddr (mk_waddr),
		.wdata (mk_wdata),
		.re    (mk_re),
		.raddr (found_q),
		.rdata (mk_rdata)
	);

	// slot / grid width divider
	assign gw_eff    = (grid_width_q == 7'd0) ? 7'd1 : grid_width_q;
	assign div_start = (state_q == gasc_pkg::ST_DIV) && !div_go_q;

	gasc_div #(.W(AW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (found_q),
		.divisor  (gw_eff),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// memory port control
	always_comb begin
		accept    = start && (state_q == gasc_pkg::ST_IDLE);
		key_match = pend_q && (kv_rdata[20:0] == cp_q);
		kv_re     = (state_q == gasc_pkg::ST_SCAN) && !key_match &&
		            (scan_q != CW'(SLOTS));
		kv_we     = (state_q == gasc_pkg::ST_ALLOC) && (free_q != '0);
		kv_waddr  = AW'(free_q - 1'b1);
		kv_wdata  = {gh_in_q, gw_in_q, cp_q};
		mk_re     = div_start;
		used_next = mark_q ? used_q : used_q + 1'b1;
		if (state_q == gasc_pkg::ST_CLR) begin
			mk_we    = 1'b1;
			mk_waddr = clr_q;
			mk_wdata = 1'b0;
		end else begin
			mk_we    = (state_q == gasc_pkg::ST_MARK) && !mark_q;
			mk_waddr = found_q;
			mk_wdata = 1'b1;
		end
		prod_x = {8'd0, div_rem} * {7'd0, cell_size_q};
		prod_y = {8'd0, div_quot} * {AW'(0), cell_size_q};
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= gasc_pkg::ST_CLR;
			clr_q      <= '0;
			free_q     <= CW'(SLOTS);
			used_q     <= '0;
			scan_q     <= '0;
			pend_q     <= 1'b0;
			div_go_q   <= 1'b0;
			mark_rd_q  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			mark_rd_q <= mk_re;
			case (state_q)
				gasc_pkg::ST_IDLE: begin
					if (accept) begin
						if (action == gasc_pkg::ACT_FLUSH) begin
							done_q  <= 1'b1;
							used_q  <= '0;
							clr_q   <= '0;
							state_q <= gasc_pkg::ST_CLR;
						end else if (free_q == CW'(SLOTS)) begin
							state_q <= gasc_pkg::ST_ALLOC;
						end else begin
							scan_q  <= free_q;
							pend_q  <= 1'b0;
							state_q <= gasc_pkg::ST_SCAN;
						end
					end
				end
				gasc_pkg::ST_SCAN: begin
					if (key_match) begin
						div_go_q <= 1'b0;
						state_q  <= gasc_pkg::ST_DIV;
					end else if (kv_re) begin
						pend_q <= 1'b1;
						scan_q <= scan_q + 1'b1;
					end else begin
						state_q <= gasc_pkg::ST_ALLOC;
					end
				end
				gasc_pkg::ST_ALLOC: begin
					if (free_q == '0) begin
						done_q  <= 1'b1;
						state_q <= gasc_pkg::ST_IDLE;
					end else begin
						free_q   <= free_q - 1'b1;
						div_go_q <= 1'b0;
						state_q  <= gasc_pkg::ST_DIV;
					end
				end
				gasc_pkg::ST_DIV: begin
					div_go_q <= 1'b1;
					if (div_done) begin
						state_q <= gasc_pkg::ST_MUL;
					end
				end
				gasc_pkg::ST_MUL: begin
					state_q <= gasc_pkg::ST_MARK;
				end
				gasc_pkg::ST_MARK: begin
					done_q <= 1'b1;
					if (used_next == CW'(SLOTS)) begin
						used_q  <= '0;
						clr_q   <= '0;
						state_q <= gasc_pkg::ST_CLR;
					end else begin
						used_q  <= used_next;
						state_q <= gasc_pkg::ST_IDLE;
					end
				end
				gasc_pkg::ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(SLOTS - 1)) begin
						state_q <= gasc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= gasc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			cp_q    <= code_point;
			gw_in_q <= glyph_width;
			gh_in_q <= glyph_height;
		end
		if (kv_re) begin
			pend_addr_q <= scan_q[AW-1:0];
		end
		if ((state_q == gasc_pkg::ST_SCAN) && key_match) begin
			found_q <= pend_addr_q;
			hit_q   <= 1'b1;
			w_q     <= kv_rdata[28:21];
			h_q     <= kv_rdata[36:29];
		end
		if (kv_we) begin
			found_q <= kv_waddr;
			hit_q   <= 1'b0;
			w_q     <= gw_in_q;
			h_q     <= gh_in_q;
		end
		if (mark_rd_q) begin
			mark_q <= mk_rdata;
		end
		if (state_q == gasc_pkg::ST_MUL) begin
			x_q <= prod_x[13:0];
			y_q <= prod_y[13:0];
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (state_q == gasc_pkg::ST_MARK) begin
			hit_o_q    <= hit_q;
			slot_o_q   <= 10'(found_q);
			x_o_q      <= x_q;
			y_o_q      <= y_q;
			w_o_q      <= w_q;
			h_o_q      <= h_q;
			flush_o_q  <= (used_next == CW'(SLOTS));
			status_o_q <= gasc_pkg::STAT_OK;
		end else if (accept || (state_q == gasc_pkg::ST_ALLOC)) begin
			hit_o_q    <= 1'b0;
			slot_o_q   <= '0;
			x_o_q      <= '0;
			y_o_q      <= '0;
			w_o_q      <= '0;
			h_o_q      <= '0;
			flush_o_q  <= 1'b0;
			status_o_q <= (state_q == gasc_pkg::ST_ALLOC) ? gasc_pkg::STAT_FULL
			                                               : gasc_pkg::STAT_OK;
		end
	end

	assign busy   = (state_q != gasc_pkg::ST_IDLE);
	assign done   = done_q;
	assign hit    = hit_o_q;
	assign slot   = slot_o_q;
	assign rect_x = x_o_q;
	assign rect_y = y_o_q;
	assign rect_w = w_o_q;
	assign rect_h = h_o_q;
	assign flush  = flush_o_q;
	assign status = status_o_q;

endmodule

>>> sim/tb.sv
// Testbench for the glyph atlas slot cache: random lookups and flushes checked against a model.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 1024;

	// One result word
	typedef struct packed {
		logic        hit;
		logic [9:0]  slot;
		logic [13:0] rect_x;
		logic [13:0] rect_y;
		logic [7:0]  rect_w;
		logic [7:0]  rect_h;
		logic        flush;
		logic        status;
	} glyph_rect_t;

	// Atlas model plus queue of predicted rectangles
	class atlas_board;
		logic [7:0]  cell_px;
		logic [6:0]  grid;
		logic [20:0] keys[SLOTS];
		bit          valid[SLOTS];
		logic [15:0] sizes[SLOTS];
		int          free_slots;
		bit          marks[SLOTS];
		int          mark_count;
		glyph_rect_t pending[$];
		int          errors;

		function void reset_state();
			cell_px = gasc_pkg::CELL_SIZE_RST;
			grid = gasc_pkg::GRID_WIDTH_RST;
			foreach (valid[i]) begin
				valid[i] = 0;
				marks[i] = 0;
			end
			free_slots = SLOTS;
			mark_count = 0;
			errors = 0;
		endfunction

		function void clear_marks();
			foreach (marks[i]) marks[i] = 0;
			mark_count = 0;
		endfunction

		// Note an accepted input word
		function void note_word(logic act, logic [20:0] cp, logic [7:0] w, logic [7:0] h);
			glyph_rect_t r;
			int s;
			int g;
			bit found;
			r = '0;
			found = 0;
			s = 0;
			if (act == gasc_pkg::ACT_FLUSH) begin
				clear_marks();
				pending.push_back(r);
				return;
			end
			for (int i = 0; i < SLOTS; i++)
				if (!found && valid[i] && keys[i] == cp) begin
					found = 1;
					s = i;
				end
			if (!found) begin
				if (free_slots == 0) begin
					r.status = gasc_pkg::STAT_FULL;
					pending.push_back(r);
					return;
				end
				free_slots--;
				s = free_slots;
				keys[s] = cp;
				sizes[s] = {h, w};
				valid[s] = 1;
			end
			g = (grid == 0) ? 1 : int'(grid);
			if (!marks[s]) begin
				marks[s] = 1;
				mark_count++;
			end
			if (mark_count == SLOTS) begin
				clear_marks();
				r.flush = 1;
			end
			r.hit = found;
			r.slot = s[9:0];
			r.rect_x = 14'((s % g) * int'(cell_px));
			r.rect_y = 14'((s / g) * int'(cell_px));
			r.rect_w = sizes[s][7:0];
			r.rect_h = sizes[s][15:8];
			r.status = gasc_pkg::STAT_OK;
			pending.push_back(r);
		endfunction

		// Compare a result word with the oldest prediction
		function void check_word(glyph_rect_t got);
			glyph_rect_t e;
			if (pending.size() == 0) begin
				$error("unexpected result word");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.hit !== e.hit) begin
				$error("hit exp %0d got %0d", e.hit, got.hit); errors++;
			end
			if (got.slot !== e.slot) begin
				$error("slot exp %0d got %0d", e.slot, got.slot); errors++;
			end
			if (got.rect_x !== e.rect_x) begin
				$error("rect_x exp %0d got %0d", e.rect_x, got.rect_x); errors++;
			end
			if (got.rect_y !== e.rect_y) begin
				$error("rect_y exp %0d got %0d", e.rect_y, got.rect_y); errors++;
			end
			if (got.rect_w !== e.rect_w) begin
				$error("rect_w exp %0d got %0d", e.rect_w, got.rect_w); errors++;
			end
			if (got.rect_h !== e.rect_h) begin
				$error("rect_h exp %0d got %0d", e.rect_h, got.rect_h); errors++;
			end
			if (got.flush !== e.flush) begin
				$error("flush exp %0d got %0d", e.flush, got.flush); errors++;
			end
			if (got.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, got.status); errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic        action = 0;
	logic [20:0] code_point = 0;
	logic [7:0]  glyph_width = 0;
	logic [7:0]  glyph_height = 0;
	logic        done;
	logic        hit;
	logic [9:0]  slot;
	logic [13:0] rect_x;
	logic [13:0] rect_y;
	logic [7:0]  rect_w;
	logic [7:0]  rect_h;
	logic        flush;
	logic        status;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [2:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;

	atlas_board board;
	bit          calm;
	logic [20:0] recent[$];

	glyph_atlas_slot_cache #(.SLOTS(SLOTS)) dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Result monitor
	always @(posedge clk)
		if (arst_n && done)
			board.check_word({hit, slot, rect_x, rect_y, rect_w, rect_h, flush, status});

	// Issue one input word, with an optional random idle gap first
	task automatic send_word(logic act, logic [20:0] cp, logic [7:0] w, logic [7:0] h);
		@(posedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			while (busy) @(posedge clk);
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1;
		action <= act;
		code_point <= cp;
		glyph_width <= w;
		glyph_height <= h;
		do @(posedge clk); while (busy);
		board.note_word(act, cp, w, h);
		start <= 0;
	endtask

	task automatic lookup(logic [20:0] cp);
		send_word(gasc_pkg::ACT_LOOKUP, cp, 8'($urandom), 8'($urandom));
	endtask

	// Wait until every predicted word is back and the block is idle
	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SLOTS + 80) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == gasc_pkg::REG_CELL_SIZE)
			board.cell_px = val[7:0];
		else
			board.grid = val[6:0];
	endtask

	task automatic set_geometry(logic [7:0] c, logic [6:0] g);
		drain();
		write_reg(gasc_pkg::REG_CELL_SIZE, {24'($urandom), c});
		write_reg(gasc_pkg::REG_GRID_WIDTH, {25'($urandom), g});
	endtask

	// Lookups, some reusing recent code points, with occasional flush actions
	task automatic random_phase(int n);
		logic [20:0] cp;
		repeat (n) begin
			if ($urandom_range(0, 40) == 0) begin
				send_word(gasc_pkg::ACT_FLUSH, 21'($urandom), 8'($urandom), 8'($urandom));
			end else begin
				if (recent.size() != 0 && $urandom_range(0, 2) == 0)
					cp = recent[$urandom_range(0, recent.size() - 1)];
				else if ($urandom_range(0, 9) == 0)
					cp = 21'($urandom);
				else
					cp = 21'($urandom_range(0, 1114111));
				recent.push_back(cp);
				if (recent.size() > 64) void'(recent.pop_front());
				lookup(cp);
			end
		end
	endtask

	initial begin
		#50_000_000;
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		board = new();
		board.reset_state();
		calm = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: field extremes, hits, flush action, odd geometry
		lookup(21'd0);
		lookup(21'h1FFFFF);
		send_word(gasc_pkg::ACT_LOOKUP, 21'd1114111, 8'hFF, 8'hFF);
		send_word(gasc_pkg::ACT_LOOKUP, 21'd0, 8'h00, 8'h00);
		lookup(21'h1FFFFF);
		send_word(gasc_pkg::ACT_FLUSH, 21'h1FFFFF, 8'hFF, 8'hFF);
		set_geometry(8'd255, 7'd1);
		lookup(21'd65);
		lookup(21'd0);
		set_geometry(8'd1, 7'd0);
		lookup(21'd66);
		lookup(21'd1114111);
		set_geometry(8'd255, 7'd64);
		lookup(21'd67);
		lookup(21'h155555);
		lookup(21'h0AAAAA);

		// Random phases across geometries
		random_phase(250);
		set_geometry(8'($urandom_range(1, 255)), 7'($urandom_range(1, 64)));
		random_phase(250);
		set_geometry(8'd255, 7'd127);
		random_phase(250);
		// Sender holds off until everything is back
		while (board.pending.size() != 0) @(posedge clk);
		set_geometry(8'($urandom_range(1, 255)), 7'($urandom_range(0, 127)));
		random_phase(200);
		calm = 1;
		random_phase(150);

		drain();
		if (board.errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
